// ===== rtl/self_organizing_map_engine_macros.svh =====
// Assertion macros shared by the checker of the self-organising map engine.
`ifndef SELF_ORGANIZING_MAP_ENGINE_MACROS_SVH
`define SELF_ORGANIZING_MAP_ENGINE_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SOM_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SOM_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/som_pkg.sv =====
// Shared constants, types and helper functions of the self-organising map engine.
package som_pkg;

   localparam int MAP_SIDE_DEF = 16;
   localparam int VEC_LEN_DEF  = 8;

   // Item function codes.
   localparam logic [1:0] FUNC_LOAD     = 2'd0;
   localparam logic [1:0] FUNC_CLASSIFY = 2'd1;
   localparam logic [1:0] FUNC_TRAIN    = 2'd2;

   // Index width for a count of n, never below one bit.
   function automatic int idx_w(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // new search: clear accumulator and best flag
      logic issue;     // read the entry addressed this cycle
      logic train;     // the issued read belongs to a training pass
      logic last_k;    // the issued read is the last component of a node
      logic load_rsp;  // copy the winner into the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic busy;         // reads still travelling through the pipeline
      logic rsp_pending;  // a result waits to be transferred
   } stat_type;

endpackage

// ===== rtl/som_dpath.sv =====
// Datapath: weight and sample memories, distance pipeline, update pipeline, result register.
module som_dpath #(
   parameter int MAP_SIDE = som_pkg::MAP_SIDE_DEF,
   parameter int VEC_LEN  = som_pkg::VEC_LEN_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_accept,
   input  logic [1:0]                               req_func,
   input  logic signed [15:0]                       req_value,
   input  logic [3:0]                               req_node_x,
   input  logic [3:0]                               req_node_y,
   input  logic [2:0]                               req_component,
   input  logic                                     req_last,
   input  logic [15:0]                              req_learn_rate,
   input  logic [4:0]                               req_radius,
   input  som_pkg::cmd_type                         cmd,
   input  logic [som_pkg::idx_w(MAP_SIDE)-1:0]      cmd_x,
   input  logic [som_pkg::idx_w(MAP_SIDE)-1:0]      cmd_y,
   input  logic [som_pkg::idx_w(VEC_LEN)-1:0]       cmd_k,
   output som_pkg::stat_type                        stat,
   output logic [som_pkg::idx_w(MAP_SIDE)-1:0]      best_x,
   output logic [som_pkg::idx_w(MAP_SIDE)-1:0]      best_y,
   output logic [4:0]                               radius_q,
   input  logic                                     rsp_stall,
   output logic                                     rsp_valid,
   output logic [3:0]                               rsp_winner_x,
   output logic [3:0]                               rsp_winner_y
);
   import som_pkg::*;

   localparam int XW    = idx_w(MAP_SIDE);
   localparam int KW    = idx_w(VEC_LEN);
   localparam int AW    = 2 * XW + KW;
   localparam int DEPTH = 1 << AW;
   localparam int SW    = 34 + KW;

   logic signed [15:0] wmem [0:DEPTH-1];
   logic signed [15:0] smem [0:(1 << KW)-1];

   logic               load_we, samp_we, train_we;
   logic [AW-1:0]      load_addr, rd_addr;
   logic signed [15:0] new_w;

   logic [15:0]        rate_ff;
   logic [4:0]         radius_ff;

   // Stage A: registered memory reads and tags.
   logic               a_valid_ff, a_train_ff, a_last_ff;
   logic [AW-1:0]      a_addr_ff;
   logic [XW-1:0]      a_x_ff, a_y_ff;
   logic signed [15:0] w_rd_ff, s_rd_ff;

   // Stage B: products.
   logic               b_valid_ff, b_train_ff, b_last_ff;
   logic [AW-1:0]      b_addr_ff;
   logic [XW-1:0]      b_x_ff, b_y_ff;
   logic signed [15:0] b_w_ff;
   logic [33:0]        sq_ff;
   logic signed [33:0] prod_ff;
   logic signed [16:0] diff;

   // Stage C: accumulation and best-node tracking.
   logic [SW-1:0]      acc_ff, best_ff, dist_sum;
   logic               have_ff;
   logic [XW-1:0]      bx_ff, by_ff;
   logic signed [33:0] adj, upd;

   logic               rsp_valid_ff;
   logic [3:0]         rsp_x_ff, rsp_y_ff;

   // Load and sample write qualifiers.
   assign load_we = req_accept && (req_func == FUNC_LOAD)
                    && (32'(req_node_x) < MAP_SIDE) && (32'(req_node_y) < MAP_SIDE)
                    && (32'(req_component) < VEC_LEN);
   assign samp_we = req_accept && (req_func == FUNC_CLASSIFY || req_func == FUNC_TRAIN)
                    && (32'(req_component) < VEC_LEN);
   assign load_addr = {XW'(req_node_y), XW'(req_node_x), KW'(req_component)};
   assign rd_addr   = {cmd_y, cmd_x, cmd_k};
   assign train_we  = b_valid_ff && b_train_ff;

   // Weight memory write port: training write-back or a load.
   always_ff @(posedge clock) begin
      if (train_we) begin
         wmem[b_addr_ff] <= new_w;
      end else if (load_we) begin
         wmem[load_addr] <= req_value;
      end
   end

   // Sample buffer write port.
   always_ff @(posedge clock) begin
      if (samp_we) begin
         smem[KW'(req_component)] <= req_value;
      end
   end

   // Gain and radius are updated by every accepted sample item, so the item that ends a sample sets them last.
   always_ff @(posedge clock) begin
      if (samp_we || (req_accept && req_last && req_func != FUNC_LOAD)) begin
         rate_ff   <= req_learn_rate;
         radius_ff <= req_radius;
      end
   end

   // Registered reads of both memories.
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         w_rd_ff <= wmem[rd_addr];
         s_rd_ff <= smem[cmd_k];
      end
      a_addr_ff  <= rd_addr;
      a_x_ff     <= cmd_x;
      a_y_ff     <= cmd_y;
      a_train_ff <= cmd.train;
      a_last_ff  <= cmd.last_k;
   end

   // Difference, square for the search and scaled step for training.
   assign diff = 17'(s_rd_ff) - 17'(w_rd_ff);

   always_ff @(posedge clock) begin
      sq_ff      <= 34'(diff * diff);
      prod_ff    <= $signed({1'b0, rate_ff}) * diff;
      b_w_ff     <= w_rd_ff;
      b_addr_ff  <= a_addr_ff;
      b_x_ff     <= a_x_ff;
      b_y_ff     <= a_y_ff;
      b_train_ff <= a_train_ff;
      b_last_ff  <= a_last_ff;
   end

   // Pipeline valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= cmd.issue;
         b_valid_ff <= a_valid_ff;
      end
   end

   // Step divided by 65536 with truncation toward zero, then added to the weight.
   assign adj   = prod_ff + (prod_ff[33] ? 34'sd65535 : 34'sd0);
   assign upd   = 34'(b_w_ff) + (adj >>> 16);
   assign new_w = upd[15:0];

   // Accumulate squared differences; a strictly smaller sum takes the lead.
   assign dist_sum = acc_ff + SW'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (cmd.start) begin
         have_ff <= 1'b0;
      end else if (b_valid_ff && !b_train_ff && b_last_ff
                   && (!have_ff || dist_sum < best_ff)) begin
         have_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (b_valid_ff && !b_train_ff) begin
         if (b_last_ff) begin
            acc_ff <= '0;
            if (!have_ff || dist_sum < best_ff) begin
               best_ff <= dist_sum;
               bx_ff   <= b_x_ff;
               by_ff   <= b_y_ff;
            end
         end else begin
            acc_ff <= dist_sum;
         end
      end
   end

   // Result register: loaded on command, cleared by its transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_x_ff <= 4'(bx_ff);
         rsp_y_ff <= 4'(by_ff);
      end
   end

   assign stat.busy        = a_valid_ff || b_valid_ff;
   assign stat.rsp_pending = rsp_valid_ff;
   assign best_x           = bx_ff;
   assign best_y           = by_ff;
   assign radius_q         = radius_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_winner_x     = rsp_x_ff;
   assign rsp_winner_y     = rsp_y_ff;

endmodule

// ===== rtl/som_ctrl.sv =====
// Controller: state machine and address counters for search and training passes.
module som_ctrl #(
   parameter int MAP_SIDE = som_pkg::MAP_SIDE_DEF,
   parameter int VEC_LEN  = som_pkg::VEC_LEN_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_accept,
   input  logic [1:0]                               req_func,
   input  logic                                     req_last,
   output logic                                     req_stall,
   output som_pkg::cmd_type                         cmd,
   output logic [som_pkg::idx_w(MAP_SIDE)-1:0]      cmd_x,
   output logic [som_pkg::idx_w(MAP_SIDE)-1:0]      cmd_y,
   output logic [som_pkg::idx_w(VEC_LEN)-1:0]       cmd_k,
   input  som_pkg::stat_type                        stat,
   input  logic [som_pkg::idx_w(MAP_SIDE)-1:0]      best_x,
   input  logic [som_pkg::idx_w(MAP_SIDE)-1:0]      best_y,
   input  logic [4:0]                               radius_q
);
   import som_pkg::*;

   localparam int XW = idx_w(MAP_SIDE);
   localparam int KW = idx_w(VEC_LEN);
   localparam int CW = XW + 6;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_SDRAIN = 3'd2;
   localparam logic [2:0] ST_OUT    = 3'd3;
   localparam logic [2:0] ST_TRAIN  = 3'd4;
   localparam logic [2:0] ST_TDRAIN = 3'd5;

   localparam logic [XW-1:0] X_TOP = XW'(MAP_SIDE - 1);
   localparam logic [KW-1:0] K_TOP = KW'(VEC_LEN - 1);

   logic [2:0]    state_ff, state_in;
   logic [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic [KW-1:0] k_ff, k_in;
   logic [XW-1:0] xmin_ff, xmin_in, xmax_ff, xmax_in, ymax_ff, ymax_in;
   logic          train_ff, train_in;
   logic          start, last_k;
   logic [CW-1:0] rad_c, bx_c, by_c, top_c;
   logic [XW-1:0] xmin_c, xmax_c, ymin_c, ymax_c;

   assign start  = req_accept && req_last
                   && (req_func == FUNC_CLASSIFY || req_func == FUNC_TRAIN);
   assign last_k = (k_ff == K_TOP);

   // Training window around the winner, clamped to the grid.
   assign rad_c  = CW'(radius_q);
   assign bx_c   = CW'(best_x);
   assign by_c   = CW'(best_y);
   assign top_c  = CW'(X_TOP);
   assign xmin_c = (rad_c >= bx_c) ? '0 : XW'(bx_c - rad_c);
   assign ymin_c = (rad_c >= by_c) ? '0 : XW'(by_c - rad_c);
   assign xmax_c = (rad_c >= top_c - bx_c) ? X_TOP : XW'(bx_c + rad_c);
   assign ymax_c = (rad_c >= top_c - by_c) ? X_TOP : XW'(by_c + rad_c);

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      k_in     = k_ff;
      xmin_in  = xmin_ff;
      xmax_in  = xmax_ff;
      ymax_in  = ymax_ff;
      train_in = train_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.start = 1'b1;
               train_in  = (req_func == FUNC_TRAIN);
               x_in      = '0;
               y_in      = '0;
               k_in      = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue  = 1'b1;
            cmd.last_k = last_k;
            k_in = last_k ? '0 : k_ff + 1'b1;
            if (last_k) begin
               x_in = (x_ff == X_TOP) ? '0 : x_ff + 1'b1;
               if (x_ff == X_TOP) begin
                  y_in = y_ff + 1'b1;
                  if (y_ff == X_TOP) begin
                     state_in = ST_SDRAIN;
                  end
               end
            end
         end
         ST_SDRAIN: begin
            if (!stat.busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!stat.rsp_pending) begin
               cmd.load_rsp = 1'b1;
               xmin_in = xmin_c;
               xmax_in = xmax_c;
               ymax_in = ymax_c;
               x_in    = xmin_c;
               y_in    = ymin_c;
               k_in    = '0;
               state_in = train_ff ? ST_TRAIN : ST_IDLE;
            end
         end
         ST_TRAIN: begin
            cmd.issue  = 1'b1;
            cmd.train  = 1'b1;
            cmd.last_k = last_k;
            k_in = last_k ? '0 : k_ff + 1'b1;
            if (last_k) begin
               x_in = (x_ff == xmax_ff) ? xmin_ff : x_ff + 1'b1;
               if (x_ff == xmax_ff) begin
                  y_in = y_ff + 1'b1;
                  if (y_ff == ymax_ff) begin
                     state_in = ST_TDRAIN;
                  end
               end
            end
         end
         ST_TDRAIN: begin
            if (!stat.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         train_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         train_ff <= train_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      k_ff    <= k_in;
      xmin_ff <= xmin_in;
      xmax_ff <= xmax_in;
      ymax_ff <= ymax_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign cmd_x     = x_ff;
   assign cmd_y     = y_ff;
   assign cmd_k     = k_ff;

endmodule

// ===== rtl/self_organizing_map_engine.sv =====
// Kohonen map engine: load and non-final sample items are written into the memories.
// A final sample item scans MAP_SIDE*MAP_SIDE*VEC_LEN weights, one per cycle through
// the single weight memory read port, 2048 weights at the defaults, before the result.
// A training pass then rereads and rewrites the window around the winner.
// Synchronous active-high reset clears control state; memories hold garbage until written.
module self_organizing_map_engine #(
   parameter int MAP_SIDE = som_pkg::MAP_SIDE_DEF,
   parameter int VEC_LEN  = som_pkg::VEC_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic signed [15:0] req_value,
   input  logic [3:0]         req_node_x,
   input  logic [3:0]         req_node_y,
   input  logic [2:0]         req_component,
   input  logic               req_last,
   input  logic [15:0]        req_learn_rate,
   input  logic [4:0]         req_radius,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_winner_x,
   output logic [3:0]         rsp_winner_y
);
   import som_pkg::*;

   localparam int XW = idx_w(MAP_SIDE);
   localparam int KW = idx_w(VEC_LEN);

   logic          req_accept;
   cmd_type       cmd;
   stat_type      stat;
   logic [XW-1:0] cmd_x, cmd_y, best_x, best_y;
   logic [KW-1:0] cmd_k;
   logic [4:0]    radius_q;

   // Input transfer.
   assign req_accept = req_valid && !req_stall;

   som_ctrl #(.MAP_SIDE(MAP_SIDE), .VEC_LEN(VEC_LEN)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_func   (req_func),
      .req_last   (req_last),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .cmd_x      (cmd_x),
      .cmd_y      (cmd_y),
      .cmd_k      (cmd_k),
      .stat       (stat),
      .best_x     (best_x),
      .best_y     (best_y),
      .radius_q   (radius_q)
   );

   som_dpath #(.MAP_SIDE(MAP_SIDE), .VEC_LEN(VEC_LEN)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_accept     (req_accept),
      .req_func       (req_func),
      .req_value      (req_value),
      .req_node_x     (req_node_x),
      .req_node_y     (req_node_y),
      .req_component  (req_component),
      .req_last       (req_last),
      .req_learn_rate (req_learn_rate),
      .req_radius     (req_radius),
      .cmd            (cmd),
      .cmd_x          (cmd_x),
      .cmd_y          (cmd_y),
      .cmd_k          (cmd_k),
      .stat           (stat),
      .best_x         (best_x),
      .best_y         (best_y),
      .radius_q       (radius_q),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_winner_x   (rsp_winner_x),
      .rsp_winner_y   (rsp_winner_y)
   );

endmodule

// ===== rtl/som_checker.sv =====
// Port-level checker of the self-organising map engine and its bind statement.
`include "self_organizing_map_engine_macros.svh"

module som_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_func,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_winner_x,
   input logic [3:0] rsp_winner_y
);
   import som_pkg::*;

   // A result held back by the receiver stays offered and unchanged.
   `SOM_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")
   `SOM_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_winner_x) && $stable(rsp_winner_y), "stalled result changed")

   // A search occupies the engine, so a final sample item is followed by stall.
   `SOM_ASSERT_RST(a_busy_after_last, clock, reset, req_valid && !req_stall && req_last && (req_func == FUNC_CLASSIFY || req_func == FUNC_TRAIN) |=> req_stall, "engine not busy after search start")

   // Each search yields one result, so a transferred result is not followed at once by another.
   `SOM_ASSERT_RST(a_single_rsp, clock, reset, rsp_valid && !rsp_stall |=> !rsp_valid, "result repeated")

   // No result appears straight out of reset.
   `SOM_ASSERT(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "result offered after reset")

endmodule

bind self_organizing_map_engine som_checker u_som_checker (.*);
